>>> design/mbrf_pkg.sv
// Package for the multi-byte ring FIFO: request and result structs, request codes,
// control and status structs shared by the controller and the datapath.
// Depends on nothing.
package mbrf_pkg;

    localparam int DATA_W    = 64;
    localparam int LEN_W     = 4;
    localparam int COUNT_W   = 11;
    localparam int LOG_W     = 4;
    localparam int LANE_W    = 3;
    localparam logic [LOG_W-1:0] SIZE_LOG2_RESET = 4'd10;

    localparam logic [2:0] REQ_WRITE = 3'd0;
    localparam logic [2:0] REQ_READ  = 3'd1;
    localparam logic [2:0] REQ_PEEK  = 3'd2;
    localparam logic [2:0] REQ_SKIP  = 3'd3;
    localparam logic [2:0] REQ_CLEAR = 3'd4;

    typedef struct packed {
        logic [2:0]        req_type;
        logic [LEN_W-1:0]  length;
        logic [DATA_W-1:0] write_data;
    } req_t;

    typedef struct packed {
        logic               status;
        logic [DATA_W-1:0]  read_data;
        logic [LEN_W-1:0]   done_length;
        logic [COUNT_W-1:0] used_count;
        logic [COUNT_W-1:0] free_count;
        logic               empty_flag;
        logic               full_flag;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic wr_byte;
        logic rd_byte;
        logic commit;
    } ctl_cmd_t;

    typedef struct packed {
        logic op_write;
        logic op_read;
        logic refused;
        logic zero_len;
        logic last_byte;
    } dp_stat_t;

endpackage

>>> design/multi_byte_ring_fifo.sv
// Top level of the multi-byte ring FIFO: joins the controller and the datapath.
// Depends on mbrf_pkg, mbrf_ctrl, mbrf_dpath and mbrf_ram.
//
//   Channel   Ports               Handshake
//   request   start, busy, req    accepted at a clock edge with start high and busy low
//   result    done, rsp           done high for one cycle, cannot be held off
//   config    cfg_we, cfg_data    written at a clock edge with cfg_we high
//
// A transaction goes from idle via evaluation to commit; zero-length, refused, skip,
// clear and unknown requests add nothing, a write adds a write step per byte and a read
// or peek a read step per byte and a drain step, since the byte store has one port that
// moves one byte a cycle. The result strobe comes in the cycle after commit, with busy low.
// Reset clears both counters and sets size_log2 to 10; the store is not cleared.
module multi_byte_ring_fifo #(
    parameter int MAX_DEPTH     = 1024,
    parameter int BYTES_PER_REQ = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  mbrf_pkg::req_t             req,
    input  logic                       cfg_we,
    input  logic [mbrf_pkg::LOG_W-1:0] cfg_data,
    output logic                       done,
    output mbrf_pkg::rsp_t             rsp
);

    mbrf_pkg::ctl_cmd_t cmd;
    mbrf_pkg::dp_stat_t stat;

    mbrf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    mbrf_dpath #(
        .MAX_DEPTH     (MAX_DEPTH),
        .BYTES_PER_REQ (BYTES_PER_REQ)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .stat     (stat),
        .done     (done),
        .rsp      (rsp)
    );

endmodule

>>> design/mbrf_ram.sv
// Generic single-port RAM with a registered read for the ring FIFO byte store.
// Depends on nothing.
module mbrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> design/mbrf_ctrl.sv
// Controller state machine of the ring FIFO: sequences one transaction byte by byte.
// Depends on mbrf_pkg.
module mbrf_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  mbrf_pkg::dp_stat_t stat,
    output mbrf_pkg::ctl_cmd_t cmd
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_EVAL   = 6'b000010,
        ST_WRITE  = 6'b000100,
        ST_READ   = 6'b001000,
        ST_DRAIN  = 6'b010000,
        ST_COMMIT = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (stat.refused || stat.zero_len)
                begin
                    state_next = ST_COMMIT;
                end
                else if (stat.op_write)
                begin
                    state_next = ST_WRITE;
                end
                else if (stat.op_read)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_WRITE:
            begin
                cmd.wr_byte = 1'b1;
                if (stat.last_byte)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_READ:
            begin
                cmd.rd_byte = 1'b1;
                if (stat.last_byte)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !busy)
        else $error("Transaction loaded while busy.");

    a_commit_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> !busy)
        else $error("Controller did not return to idle after commit.");

    a_eval_follows_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == ST_EVAL)
        else $error("Evaluation step skipped after load.");

endmodule

>>> design/mbrf_dpath.sv
// Datapath of the ring FIFO: request and size registers, counters, byte store,
// occupancy arithmetic and the result register. Depends on mbrf_pkg and mbrf_ram.
module mbrf_dpath #(
    parameter int MAX_DEPTH     = 1024,
    parameter int BYTES_PER_REQ = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mbrf_pkg::req_t                  req,
    input  logic                            cfg_we,
    input  logic [mbrf_pkg::LOG_W-1:0]      cfg_data,
    input  mbrf_pkg::ctl_cmd_t              cmd,
    output mbrf_pkg::dp_stat_t              stat,
    output logic                            done,
    output mbrf_pkg::rsp_t                  rsp
);

    localparam int MAX_LOG2 = $clog2(MAX_DEPTH + 1) - 1;
    localparam int ADDR_W   = MAX_LOG2;
    localparam int CNT_W    = MAX_LOG2 + 1;
    localparam int EFF_W    = $clog2(MAX_LOG2 + 1);
    localparam int CMP_W    = CNT_W + mbrf_pkg::LEN_W;
    localparam int LEN_W    = mbrf_pkg::LEN_W;

    mbrf_pkg::req_t                    req_reg;
    logic [LEN_W-1:0]                  len_reg;
    logic [mbrf_pkg::LOG_W-1:0]        size_reg;
    logic [CNT_W-1:0]                  wc_reg;
    logic [CNT_W-1:0]                  wc_next;
    logic [CNT_W-1:0]                  rc_reg;
    logic [CNT_W-1:0]                  rc_next;
    logic [LEN_W-1:0]                  cnt_reg;
    logic [mbrf_pkg::LANE_W-1:0]       lane_reg;
    logic                              cap_v_reg;
    logic [mbrf_pkg::DATA_W-1:0]       rdata_reg;
    logic                              done_reg;
    mbrf_pkg::rsp_t                    rsp_reg;
    mbrf_pkg::rsp_t                    rsp_next;

    logic [EFF_W-1:0]  eff_log2;
    logic [CNT_W-1:0]  cap;
    logic [CNT_W-1:0]  cap_m1;
    logic [CNT_W-1:0]  used;
    logic [CNT_W-1:0]  free_b;
    logic [CNT_W-1:0]  used_n;
    logic              full_n;
    logic [CNT_W-1:0]  len_ext;
    logic [CMP_W-1:0]  base_sum;
    logic [ADDR_W-1:0] ram_addr;
    logic [7:0]        ram_rdata;
    logic              is_read_type;

    always_comb
    begin
        if (size_reg == '0)
        begin
            eff_log2 = EFF_W'(1);
        end
        else if (int'(size_reg) > MAX_LOG2)
        begin
            eff_log2 = EFF_W'(MAX_LOG2);
        end
        else
        begin
            eff_log2 = EFF_W'(size_reg);
        end
    end

    assign cap     = CNT_W'(1) << eff_log2;
    assign cap_m1  = cap - CNT_W'(1);
    assign used    = wc_reg - rc_reg;
    assign free_b  = (used >= cap) ? '0 : cap - used;
    assign len_ext = CNT_W'(len_reg);

    assign is_read_type = (req_reg.req_type == mbrf_pkg::REQ_READ)
                       || (req_reg.req_type == mbrf_pkg::REQ_PEEK)
                       || (req_reg.req_type == mbrf_pkg::REQ_SKIP);

    always_comb
    begin
        stat           = '0;
        stat.op_write  = (req_reg.req_type == mbrf_pkg::REQ_WRITE);
        stat.op_read   = (req_reg.req_type == mbrf_pkg::REQ_READ)
                      || (req_reg.req_type == mbrf_pkg::REQ_PEEK);
        stat.zero_len  = (len_reg == '0);
        stat.last_byte = ((cnt_reg + LEN_W'(1)) == len_reg);
        if (stat.op_write)
        begin
            stat.refused = CMP_W'(len_reg) > CMP_W'(free_b);
        end
        else if (is_read_type)
        begin
            stat.refused = CMP_W'(len_reg) > CMP_W'(used);
        end
    end

    always_comb
    begin
        if (stat.op_write)
        begin
            base_sum = CMP_W'(wc_reg) + CMP_W'(cnt_reg);
        end
        else
        begin
            base_sum = CMP_W'(rc_reg) + CMP_W'(cnt_reg);
        end
        ram_addr = base_sum[ADDR_W-1:0] & cap_m1[ADDR_W-1:0];
    end

    mbrf_ram #(
        .WIDTH (8),
        .DEPTH (1 << MAX_LOG2)
    ) u_store (
        .clk   (clk),
        .we    (cmd.wr_byte),
        .addr  (ram_addr),
        .wdata (req_reg.write_data[{cnt_reg[mbrf_pkg::LANE_W-1:0], 3'b000} +: 8]),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        wc_next = wc_reg;
        rc_next = rc_reg;
        if (cmd.commit)
        begin
            if (req_reg.req_type == mbrf_pkg::REQ_CLEAR)
            begin
                wc_next = '0;
                rc_next = '0;
            end
            else if (!stat.refused)
            begin
                if (stat.op_write)
                begin
                    wc_next = wc_reg + len_ext;
                end
                else if ((req_reg.req_type == mbrf_pkg::REQ_READ)
                      || (req_reg.req_type == mbrf_pkg::REQ_SKIP))
                begin
                    rc_next = rc_reg + len_ext;
                end
            end
        end
    end

    assign used_n = wc_next - rc_next;
    assign full_n = (used_n >= cap);

    always_comb
    begin
        rsp_next            = '0;
        rsp_next.status     = stat.refused;
        rsp_next.read_data  = rdata_reg;
        rsp_next.done_length = (!stat.refused && (stat.op_write || is_read_type))
                             ? len_reg : '0;
        rsp_next.used_count = mbrf_pkg::COUNT_W'(used_n);
        rsp_next.free_count = full_n ? '0 : mbrf_pkg::COUNT_W'(cap - used_n);
        rsp_next.empty_flag = (used_n == '0);
        rsp_next.full_flag  = full_n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg  <= mbrf_pkg::SIZE_LOG2_RESET;
            wc_reg    <= '0;
            rc_reg    <= '0;
            cnt_reg   <= '0;
            cap_v_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                size_reg <= cfg_data;
            end
            wc_reg    <= wc_next;
            rc_reg    <= rc_next;
            cap_v_reg <= cmd.rd_byte;
            done_reg  <= cmd.commit;
            if (cmd.load)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.wr_byte || cmd.rd_byte)
            begin
                cnt_reg <= cnt_reg + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg   <= req;
            len_reg   <= (req.length > LEN_W'(BYTES_PER_REQ)) ? LEN_W'(BYTES_PER_REQ)
                                                              : req.length;
            rdata_reg <= '0;
        end
        else if (cap_v_reg)
        begin
            rdata_reg[{lane_reg, 3'b000} +: 8] <= ram_rdata;
        end
        lane_reg <= cnt_reg[mbrf_pkg::LANE_W-1:0];
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_refused_moves_nothing: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.status |-> rsp.done_length == '0 && rsp.read_data == '0)
        else $error("Refused transaction reported transferred bytes.");

    a_counters_only_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.commit |=> $stable(wc_reg) && $stable(rc_reg))
        else $error("Counters changed outside a commit.");

    a_no_commit_with_capture: assert property (@(posedge clk) disable iff (!rst_n)
        cap_v_reg |-> !cmd.commit)
        else $error("Commit while a read byte is still in flight.");

    a_not_empty_and_full: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(rsp.empty_flag && rsp.full_flag))
        else $error("Result flags empty and full together.");

endmodule
